// File: rtl/cwi_pkg.sv
// ----------------------------------------------------------------------------
// cwi_pkg - shared types and constants for the CCI window indicator
// Widths of the price, sum and divider paths, controller state encoding and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cwi_pkg;

	localparam int PRICE_W    = 24;            // one price field
	localparam int SUM_W      = PRICE_W + 2;   // high + low + close
	localparam int NW         = 5;             // window length register
	localparam int MAX_WINDOW = 16;
	localparam int PTR_W      = 4;             // ring index
	localparam int TOT_W      = SUM_W + PTR_W; // window total, N * S
	localparam int DEV_W      = TOT_W + PTR_W; // sum of absolute deviations
	localparam int DEN_W      = DEV_W + 2;     // 3 * deviation
	localparam int PROD_W     = TOT_W + PTR_W; // magnitude * N
	localparam int MUL_W      = PROD_W + 8;    // times 200
	localparam int FRAC_W     = 8;             // times 256
	localparam int NUM_W      = MUL_W + FRAC_W;
	localparam int Q_W        = 24;            // quotient bits kept
	localparam int SAT_W      = DEN_W + Q_W;
	localparam int DSH_W      = DEN_W + Q_W - 1;
	localparam int OUT_W      = 24;
	localparam int CNT_W      = 5;
	localparam int DIV_STEPS  = Q_W;

	localparam logic [NW-1:0]  WIN_RESET = NW'(10);
	localparam logic [7:0]     SCALE_200 = 8'd200;
	localparam logic [Q_W:0]   LIM_POS   = {2'b00, {(Q_W-1){1'b1}}};
	localparam logic [Q_W:0]   LIM_NEG   = {2'b01, {(Q_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_SUM,
		ST_DEV,
		ST_FLUSH1,
		ST_FLUSH2,
		ST_PREP,
		ST_MUL1,
		ST_MUL2,
		ST_DINIT,
		ST_DIV,
		ST_ROUND,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic cnt_clr;
		logic cnt_inc;
		logic rd_issue;
		logic rd_dev;
		logic prep;
		logic mul1;
		logic mul2;
		logic div_init;
		logic div_step;
		logic round;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic ready;
		logic pass_last;
		logic div_last;
		logic zero_dev;
		logic out_free;
	} sts_t;

	// 0 acts as 1, anything above the ring depth acts as the ring depth
	function automatic logic [NW-1:0] eff_window(input logic [NW-1:0] wl);
		logic [NW-1:0] n;
		n = wl;
		if (wl == '0)
			n = NW'(1);
		else if (wl > NW'(MAX_WINDOW))
			n = NW'(MAX_WINDOW);
		return n;
	endfunction

endpackage

// File: rtl/cwi_if.sv
// ----------------------------------------------------------------------------
// cwi_if - valid/ready channels of the CCI window indicator
// Price bar input, index result output and window length write channel.
// ----------------------------------------------------------------------------
interface cwi_in_if;
	logic                         valid;
	logic                         ready;
	logic [cwi_pkg::PRICE_W-1:0]  high_price;
	logic [cwi_pkg::PRICE_W-1:0]  low_price;
	logic [cwi_pkg::PRICE_W-1:0]  close_price;

	modport source (output valid, output high_price, output low_price,
		output close_price, input ready);
	modport sink (input valid, input high_price, input low_price,
		input close_price, output ready);
endinterface

interface cwi_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [cwi_pkg::OUT_W-1:0]  cci_value;
	logic                              window_ready;
	logic                              zero_deviation;

	modport source (output valid, output cci_value, output window_ready,
		output zero_deviation, input ready);
	modport sink (input valid, input cci_value, input window_ready,
		input zero_deviation, output ready);
endinterface

interface cwi_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [cwi_pkg::NW-1:0]  window_length;

	modport source (output valid, output window_length, input ready);
	modport sink (input valid, input window_length, output ready);
endinterface

// File: rtl/cci_window_indicator_unit.sv
// ----------------------------------------------------------------------------
// cci_window_indicator_unit - commodity channel index over a bar window
// Pace: set by the two ring passes and the 24-step serial divider, one bar in
//   flight at a time; a zero deviation skips the scaling and divide, and a
//   window that is still filling skips the ring passes as well.
// Reset: arst_n clears the ring pointer, bar count and result valid and sets
//   the window length to 10; ring contents stay undefined until written.
// ----------------------------------------------------------------------------
//
// Function
//   Each bar beat gives S = high + low + close (three times the typical
//   price). The bar is measured against the N bars before it; it enters the
//   ring only once its own index is done. With T the window sum and
//   D = sum |N*S_i - T|, the index times 256 is
//     (N*S - T) * N * 200 * 256 / (3 * D)
//   rounded to nearest, ties away from zero, and saturated to signed 24 bits.
//
// Flow per bar
//   START   branch on ready = (bars seen >= N), captured with the bar beat; not ready goes to FIN
//   SUM     N ring reads, newest first, accumulated into T
//   DEV     N ring reads again, |N*S_i - T| accumulated into D
//   FLUSH   FLUSH1 and FLUSH2 let the read and product registers drain
//   PREP    sign and magnitude of N*S - T, 3*D, zero-deviation check
//   MUL     magnitude * N, then * 200 and shifted by eight fraction bits
//   DIV     24-step restoring divide, out-of-range numerator marked first
//   ROUND   round, clamp, negate
//   FIN     result register loaded once the previous beat has been taken;
//           the ring write and bar count update happen here too
//
// Window length writes are taken at any time (ready tied high); they are
// only meaningful while the unit is idle.
// ----------------------------------------------------------------------------
module cci_window_indicator_unit (
	input  logic        clk,
	input  logic        arst_n,
	cwi_in_if.sink      bar,
	cwi_out_if.source   res,
	cwi_cfg_if.sink     cfg
);
	import cwi_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [OUT_W-1:0] cci_raw;

	// Sequencer: owns the bar handshake, issues one command set per cycle
	cwi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bar.valid),
		.in_ready (bar.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: ring, accumulators, divider and the output register that
	// decouples the result beat from the next bar
	cwi_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.high_price     (bar.high_price),
		.low_price      (bar.low_price),
		.close_price    (bar.close_price),
		.cfg_valid      (cfg.valid),
		.cfg_data       (cfg.window_length),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (res.valid),
		.out_ready      (res.ready),
		.cci_value      (cci_raw),
		.window_ready   (res.window_ready),
		.zero_deviation (res.zero_deviation)
	);

	assign res.cci_value = $signed(cci_raw);

	// Single register, always writable
	assign cfg.ready = 1'b1;

endmodule

// File: rtl/cwi_ctrl.sv
// ----------------------------------------------------------------------------
// cwi_ctrl - sequencing FSM for the CCI window indicator
// Steps one bar through window sum, deviation pass, scaling and division.
// ----------------------------------------------------------------------------
module cwi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cwi_pkg::sts_t  sts,
	output cwi_pkg::cmd_t  cmd
);
	import cwi_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_START;
			ST_START:  state_d = sts.ready ? ST_SUM : ST_FIN;
			ST_SUM:    if (sts.pass_last) state_d = ST_DEV;
			ST_DEV:    if (sts.pass_last) state_d = ST_FLUSH1;
			ST_FLUSH1: state_d = ST_FLUSH2;
			ST_FLUSH2: state_d = ST_PREP;
			ST_PREP:   state_d = sts.zero_dev ? ST_FIN : ST_MUL1;
			ST_MUL1:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_DINIT;
			ST_DINIT:  state_d = ST_DIV;
			ST_DIV:    if (sts.div_last) state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_FIN;
			ST_FIN:    if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_START: cmd.cnt_clr = 1'b1;
			ST_SUM: begin
				cmd.rd_issue = 1'b1;
				cmd.cnt_inc  = 1'b1;
				cmd.cnt_clr  = sts.pass_last;
			end
			ST_DEV: begin
				cmd.rd_issue = 1'b1;
				cmd.rd_dev   = 1'b1;
				cmd.cnt_inc  = 1'b1;
			end
			ST_FLUSH1, ST_FLUSH2: ;
			ST_PREP:  cmd.prep = 1'b1;
			ST_MUL1:  cmd.mul1 = 1'b1;
			ST_MUL2:  cmd.mul2 = 1'b1;
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cmd.cnt_clr  = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.cnt_inc  = 1'b1;
			end
			ST_ROUND: cmd.round  = 1'b1;
			ST_FIN:   cmd.finish = sts.out_free;
			default: ;
		endcase
	end

endmodule

// File: rtl/cwi_dp.sv
// ----------------------------------------------------------------------------
// cwi_dp - datapath of the CCI window indicator
// Typical price ring, sum and deviation accumulators, scaling multipliers,
// restoring divider with rounding and saturation, result register.
// ----------------------------------------------------------------------------
module cwi_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cwi_pkg::PRICE_W-1:0]   high_price,
	input  logic [cwi_pkg::PRICE_W-1:0]   low_price,
	input  logic [cwi_pkg::PRICE_W-1:0]   close_price,
	input  logic                          cfg_valid,
	input  logic [cwi_pkg::NW-1:0]        cfg_data,
	input  cwi_pkg::cmd_t                 cmd,
	output cwi_pkg::sts_t                 sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cwi_pkg::OUT_W-1:0]     cci_value,
	output logic                          window_ready,
	output logic                          zero_deviation
);
	import cwi_pkg::*;

	// control state
	logic [NW-1:0]    win_len_q;
	logic [PTR_W-1:0] ptr_q;
	logic [NW-1:0]    bars_seen_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_vld_s1;
	logic             rd_dev_s1;
	logic             dev_vld_s2;
	logic             out_valid_q;

	// payload
	logic [SUM_W-1:0] ring_q [MAX_WINDOW];
	logic [SUM_W-1:0] rd_data_s1;
	logic [TOT_W-1:0] prod_s2;
	logic [SUM_W-1:0] s_cur_q;
	logic [NW-1:0]    n_q;
	logic             ready_q;
	logic [TOT_W-1:0] a_q;
	logic [TOT_W-1:0] total_q;
	logic [DEV_W-1:0] dev_q;
	logic [TOT_W-1:0] mag_q;
	logic             neg_q;
	logic             zero_q;
	logic [DEN_W-1:0] den_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0] num_q;
	logic             sat_q;
	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [Q_W-1:0]   q_q;
	logic [OUT_W-1:0] val_q;
	logic [OUT_W-1:0] cci_q;
	logic             wr_q;
	logic             zd_q;

	logic [SUM_W-1:0] s_in;
	logic [PTR_W-1:0] rd_addr;
	logic [TOT_W-1:0] abs_dev;
	logic [DSH_W-1:0] rem_x;
	logic             rem_ge;
	logic             rnd_up;
	logic [Q_W:0]     q_rnd;
	logic [Q_W:0]     lim;
	logic [Q_W:0]     mag_c;

	always_comb begin
		s_in    = SUM_W'(high_price) + SUM_W'(low_price) + SUM_W'(close_price);
		// newest entry first: ptr - 1 - k
		rd_addr = ptr_q + ~cnt_q[PTR_W-1:0];
		abs_dev = (prod_s2 >= total_q) ? (prod_s2 - total_q) : (total_q - prod_s2);
		rem_x   = DSH_W'(rem_q);
		rem_ge  = rem_x >= dsh_q;
		rnd_up  = {rem_q[DEN_W-1:0], 1'b0} >= {1'b0, den_q};
		q_rnd   = {1'b0, q_q} + (Q_W+1)'(rnd_up);
		lim     = neg_q ? LIM_NEG : LIM_POS;
		mag_c   = (sat_q || (q_rnd > lim)) ? lim : q_rnd;
	end

	always_comb begin
		sts.ready     = ready_q;
		sts.pass_last = cnt_q == (n_q - NW'(1));
		sts.div_last  = cnt_q == CNT_W'(DIV_STEPS - 1);
		sts.zero_dev  = dev_q == '0;
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WIN_RESET;
			ptr_q       <= '0;
			bars_seen_q <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_dev_s1   <= 1'b0;
			dev_vld_s2  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				win_len_q <= cfg_data;
			if (cmd.cnt_clr)
				cnt_q <= '0;
			else if (cmd.cnt_inc)
				cnt_q <= cnt_q + CNT_W'(1);
			rd_vld_s1  <= cmd.rd_issue;
			rd_dev_s1  <= cmd.rd_dev;
			dev_vld_s2 <= rd_vld_s1 && rd_dev_s1;
			if (cmd.finish) begin
				ptr_q       <= ptr_q + PTR_W'(1);
				if (bars_seen_q < n_q)
					bars_seen_q <= bars_seen_q + NW'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ring storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.finish)
			ring_q[ptr_q] <= s_cur_q;
		if (cmd.rd_issue)
			rd_data_s1 <= ring_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		a_q     <= TOT_W'(TOT_W'(n_q) * TOT_W'(s_cur_q));
		prod_s2 <= TOT_W'(TOT_W'(n_q) * TOT_W'(rd_data_s1));

		if (cmd.load) begin
			s_cur_q <= s_in;
			n_q     <= eff_window(win_len_q);
			ready_q <= bars_seen_q >= eff_window(win_len_q);
			total_q <= '0;
			dev_q   <= '0;
		end else begin
			if (rd_vld_s1 && !rd_dev_s1)
				total_q <= total_q + TOT_W'(rd_data_s1);
			if (dev_vld_s2)
				dev_q <= dev_q + DEV_W'(abs_dev);
		end

		if (cmd.prep) begin
			neg_q  <= a_q < total_q;
			mag_q  <= (a_q < total_q) ? (total_q - a_q) : (a_q - total_q);
			den_q  <= DEN_W'(dev_q) + DEN_W'({dev_q, 1'b0});
			zero_q <= dev_q == '0;
		end
		if (cmd.mul1)
			prod_q <= PROD_W'(PROD_W'(mag_q) * PROD_W'(n_q));
		if (cmd.mul2)
			num_q <= {MUL_W'(MUL_W'(prod_q) * MUL_W'(SCALE_200)), {FRAC_W{1'b0}}};

		if (cmd.div_init) begin
			sat_q <= SAT_W'(num_q) >= {den_q, {Q_W{1'b0}}};
			rem_q <= num_q;
			dsh_q <= {den_q, {(Q_W-1){1'b0}}};
			q_q   <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge)
				rem_q <= NUM_W'(rem_x - dsh_q);
			q_q   <= {q_q[Q_W-2:0], rem_ge};
			dsh_q <= dsh_q >> 1;
		end

		if (cmd.round)
			val_q <= neg_q ? (~mag_c[OUT_W-1:0] + OUT_W'(1)) : mag_c[OUT_W-1:0];

		if (cmd.finish) begin
			cci_q <= (ready_q && !zero_q) ? val_q : '0;
			wr_q  <= ready_q;
			zd_q  <= ready_q && zero_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign cci_value      = cci_q;
	assign window_ready   = wr_q;
	assign zero_deviation = zd_q;

endmodule

// File: rtl/cwi_checker.sv
// ----------------------------------------------------------------------------
// cwi_checker - port-level checks for the CCI window indicator
// Result flag consistency, output hold and one-bar-at-a-time intake.
// ----------------------------------------------------------------------------
module cwi_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic signed [cwi_pkg::OUT_W-1:0] cci_value,
	input  logic                             window_ready,
	input  logic                             zero_deviation
);

	// a result beat still waiting keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cci_value))
		else $error("result beat changed while stalled");

	// filling window gives a plain zero result
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_ready |-> cci_value == '0 && !zero_deviation)
		else $error("non-zero result before the window is full");

	// flat window forces the index to zero
	a_zero_dev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_deviation |-> cci_value == '0 && window_ready)
		else $error("zero deviation flagged with non-zero index");

	// one bar in flight: intake closes right after a bar beat
	a_one_bar: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second bar taken while one is in progress");

endmodule

bind cci_window_indicator_unit cwi_checker u_cwi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (bar.valid),
	.in_ready       (bar.ready),
	.out_valid      (res.valid),
	.out_ready      (res.ready),
	.cci_value      (res.cci_value),
	.window_ready   (res.window_ready),
	.zero_deviation (res.zero_deviation)
);

// File: tb/tb_cci_window_indicator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cci_window_indicator_unit - self-checking bench for the CCI indicator
// A directed table (reset state, window length limits, saturation, flat
// windows) then random price bars in phases of different window lengths.
// Result beats are scored against a bench-side index model or the typed row. The bar
// sender works in bursts and the result receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_cci_window_indicator_unit;
	import cwi_pkg::*;

	// ---- run shape -----------------------------------------------------------
	localparam int NUM_PHASES     = 12;
	localparam int BARS_PER_PHASE = 112;
	localparam int SETTLE_CYCLES  = 8;                  // after the last beat, before a write
	localparam int DRAIN_CYCLES   = 2 * MAX_WINDOW + 40; // one full latency and margin
	localparam int HOLD_CYCLES    = 600;                // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 5000;               // cycles with no beat on any channel
	localparam int MAX_REPORTS    = 10;

	// 1 / 0.015 = 200/3; the 3 sits in the divisor, 256 is the Q15.8 scale
	localparam longint unsigned INDEX_SCALE = 64'd200 * 64'd256;
	localparam longint unsigned SAT_POS_MAG = 64'd8388607;
	localparam longint unsigned SAT_NEG_MAG = 64'd8388608;

	localparam logic [PRICE_W-1:0] P_ZERO = '0;
	localparam logic [PRICE_W-1:0] P_MAX  = {PRICE_W{1'b1}};
	localparam int                 P_MAX_INT = (1 << PRICE_W) - 1;

	// ---- one result beat -----------------------------------------------------
	typedef struct packed {
		logic signed [OUT_W-1:0] cci_value;
		logic                    window_ready;
		logic                    zero_deviation;
	} index_beat_t;

	localparam index_beat_t BEAT_NONE      = '0;
	localparam index_beat_t BEAT_FILLING   = '{24'sd0, 1'b0, 1'b0};
	localparam index_beat_t BEAT_FLAT      = '{24'sd0, 1'b1, 1'b1};
	localparam index_beat_t BEAT_SAT_HIGH  = '{24'sh7FFFFF, 1'b1, 1'b0};
	localparam index_beat_t BEAT_SAT_LOW   = '{24'sh800000, 1'b1, 1'b0};

	// ---- directed table ------------------------------------------------------
	typedef enum logic [1:0] {
		ROW_CFG,      // window length write, unit idle
		ROW_BAR,      // bar beat, scored by the model
		ROW_BAR_CHK   // bar beat with the result typed in
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [NW-1:0]       wl;
		logic [PRICE_W-1:0]  hi;
		logic [PRICE_W-1:0]  lo;
		logic [PRICE_W-1:0]  cl;
		index_beat_t         want;
	} stim_row_t;

	localparam int DIR_ROWS = 21;
	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		// reset length is 10: nothing ready yet
		'{ROW_BAR_CHK, 5'd0,  P_ZERO, P_ZERO, P_ZERO, BEAT_FILLING},
		'{ROW_BAR_CHK, 5'd0,  P_MAX,  P_MAX,  P_MAX,  BEAT_FILLING},
		// a single-bar window never deviates; 0 behaves as 1
		'{ROW_CFG,     5'd1,  P_ZERO, P_ZERO, P_ZERO, BEAT_NONE},
		'{ROW_BAR_CHK, 5'd0,  24'd3,  24'd4,  24'd5,  BEAT_FLAT},
		'{ROW_CFG,     5'd0,  P_ZERO, P_ZERO, P_ZERO, BEAT_NONE},
		'{ROW_BAR_CHK, 5'd0,  24'd6,  24'd7,  24'd8,  BEAT_FLAT},
		// two-bar window: tight window then a far bar saturates both ways
		'{ROW_CFG,     5'd2,  P_ZERO, P_ZERO, P_ZERO, BEAT_NONE},
		'{ROW_BAR,     5'd0,  P_ZERO, P_ZERO, P_ZERO, BEAT_NONE},
		'{ROW_BAR,     5'd0,  24'd1,  24'd1,  24'd1,  BEAT_NONE},
		'{ROW_BAR_CHK, 5'd0,  P_MAX,  P_MAX,  P_MAX,  BEAT_SAT_HIGH},
		'{ROW_BAR,     5'd0,  P_MAX,  P_MAX,  P_MAX - 24'd1, BEAT_NONE},
		'{ROW_BAR_CHK, 5'd0,  P_ZERO, P_ZERO, P_ZERO, BEAT_SAT_LOW},
		// two equal bars, then anything: zero deviation
		'{ROW_BAR,     5'd0,  24'd5,  24'd5,  24'd5,  BEAT_NONE},
		'{ROW_BAR,     5'd0,  24'd5,  24'd5,  24'd5,  BEAT_NONE},
		'{ROW_BAR_CHK, 5'd0,  24'd7,  24'd9,  24'd200, BEAT_FLAT},
		'{ROW_BAR,     5'd0,  24'hAAAAAA, 24'h555555, 24'h123456, BEAT_NONE},
		'{ROW_BAR,     5'd0,  24'h555555, 24'hAAAAAA, 24'hEDCBA9, BEAT_NONE},
		// 31 acts as 16; the bar count is kept, so the window refills
		'{ROW_CFG,     5'd31, P_ZERO, P_ZERO, P_ZERO, BEAT_NONE},
		'{ROW_BAR_CHK, 5'd0,  24'd1,  24'd2,  24'd3,  BEAT_FILLING},
		'{ROW_BAR_CHK, 5'd0,  P_MAX,  P_ZERO, P_MAX,  BEAT_FILLING},
		'{ROW_BAR_CHK, 5'd0,  P_ZERO, P_MAX,  P_ZERO, BEAT_FILLING}
	};

	// first phases pin the extremes, later ones draw at random
	localparam logic [NW-1:0] WIN_PLAN [8] = '{
		5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd16
	};

	// ---- clock, reset, channels ----------------------------------------------
	logic clk;
	logic arst_n;

	cwi_in_if  bar_if ();
	cwi_out_if res_if ();
	cwi_cfg_if cfg_if ();

	cci_window_indicator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bar    (bar_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---- bench-side index model ----------------------------------------------
	logic [SUM_W-1:0] tp3_ring [MAX_WINDOW];  // three-times typical prices
	logic [PTR_W-1:0] ring_head;              // next slot to fill
	logic [CNT_W-1:0] bar_tally;              // bars seen, held at N
	logic [NW-1:0]    win_len;                // as written, before limiting

	index_beat_t pending_index [$];            // expected result beats, oldest first

	int  err_count;
	int  beats_taken;
	int  burst_left;
	bit  hold_req;

	// random bar source state
	int                 walk_base;
	int                 flat_left;
	logic [PRICE_W-1:0] last_hi, last_lo, last_cl;

	// Index of one bar against the N bars before it, then the bar enters the
	// ring. Exact integer arithmetic on three-times-scaled sums.
	function automatic index_beat_t predict_index(input logic [PRICE_W-1:0] hi,
		input logic [PRICE_W-1:0] lo, input logic [PRICE_W-1:0] cl);
		index_beat_t        r;
		logic [SUM_W-1:0]   s_cur;
		logic [PTR_W-1:0]   slot;
		longint unsigned    n, total, dev, a, mag, num, den, q, rem;
		logic               neg;
		int                 k;

		s_cur = SUM_W'(hi) + SUM_W'(lo) + SUM_W'(cl);
		if (win_len == '0)
			n = 1;
		else if (win_len > NW'(MAX_WINDOW))
			n = 64'(MAX_WINDOW);
		else
			n = 64'(win_len);
		r = '0;

		if (bar_tally >= n) begin
			r.window_ready = 1'b1;
			total = 0;
			dev   = 0;
			for (k = 0; k < n; k++) begin
				slot  = PTR_W'(ring_head - 1 - k);
				total += tp3_ring[slot];
			end
			for (k = 0; k < n; k++) begin
				slot = PTR_W'(ring_head - 1 - k);
				a    = n * tp3_ring[slot];
				dev  += (a >= total) ? (a - total) : (total - a);
			end
			if (dev == 0) begin
				r.zero_deviation = 1'b1;
			end else begin
				a   = n * s_cur;
				neg = (a < total);
				mag = neg ? (total - a) : (a - total);
				num = mag * n * INDEX_SCALE;
				den = 3 * dev;
				q   = num / den;
				rem = num % den;
				// nearest, ties away from zero (magnitude rounds up)
				if (rem >= den - rem)
					q++;
				if (neg) begin
					if (q > SAT_NEG_MAG)
						q = SAT_NEG_MAG;
					r.cci_value = OUT_W'(64'd0 - q);
				end else begin
					if (q > SAT_POS_MAG)
						q = SAT_POS_MAG;
					r.cci_value = OUT_W'(q);
				end
			end
		end

		tp3_ring[ring_head] = s_cur;
		ring_head           = ring_head + 1'b1;
		if (bar_tally < n)
			bar_tally = bar_tally + 1'b1;
		return r;
	endfunction

	function automatic logic [PRICE_W-1:0] clamp_price(input int v);
		if (v < 0)
			return P_ZERO;
		if (v > P_MAX_INT)
			return P_MAX;
		return PRICE_W'(v);
	endfunction

	// ---- bar sender ----------------------------------------------------------
	// Bursts of back-to-back offers with random gaps between them. The beat is
	// scored at the edge it is taken; typed rows override the model's value.
	task automatic send_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
		input logic [PRICE_W-1:0] cl, input bit use_typed, input index_beat_t typed);
		index_beat_t pred;

		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				bar_if.valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		burst_left--;

		bar_if.valid       <= 1'b1;
		bar_if.high_price  <= hi;
		bar_if.low_price   <= lo;
		bar_if.close_price <= cl;
		do @(posedge clk); while (bar_if.ready !== 1'b1);

		pred = predict_index(hi, lo, cl);
		pending_index.push_back(use_typed ? typed : pred);
	endtask

	// Window length write, only with the unit idle: every result back first.
	task automatic write_window(input logic [NW-1:0] wl);
		bar_if.valid <= 1'b0;
		while (pending_index.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		cfg_if.valid         <= 1'b1;
		cfg_if.window_length <= wl;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		win_len = wl;
	endtask

	// Mostly a price random walk so the index stays in range; some raw noise,
	// some rail values, and flat runs that drive the deviation to zero.
	task automatic next_bar(output logic [PRICE_W-1:0] hi, output logic [PRICE_W-1:0] lo,
		output logic [PRICE_W-1:0] cl);
		int pick;
		int span;

		pick = $urandom_range(0, 99);
		if (flat_left > 0) begin
			flat_left--;
			hi = last_hi; lo = last_lo; cl = last_cl;
		end else if (pick < 60) begin
			if ($urandom_range(0, 49) == 0)
				walk_base = int'($urandom_range(0, P_MAX_INT));
			walk_base = int'(clamp_price(walk_base + int'($urandom_range(0, 1024)) - 512));
			span = $urandom_range(0, 2047);
			hi = clamp_price(walk_base + int'($urandom_range(0, span)));
			lo = clamp_price(walk_base - int'($urandom_range(0, span)));
			cl = clamp_price(int'(lo) + int'($urandom_range(0, int'(hi - lo))));
		end else if (pick < 80) begin
			hi = PRICE_W'($urandom);
			lo = PRICE_W'($urandom);
			cl = PRICE_W'($urandom);
		end else if (pick < 88) begin
			hi = $urandom_range(0, 1) ? P_MAX : P_ZERO;
			lo = $urandom_range(0, 1) ? P_MAX : P_ZERO;
			cl = $urandom_range(0, 1) ? P_MAX : P_ZERO;
		end else begin
			flat_left = $urandom_range(2, 18);
			hi = last_hi; lo = last_lo; cl = last_cl;
		end
		last_hi = hi; last_lo = lo; last_cl = cl;
	endtask

	// ---- main stimulus -------------------------------------------------------
	initial begin
		int                 row_i;
		int                 phase;
		int                 k;
		logic [PRICE_W-1:0] hi, lo, cl;
		stim_row_t          row;

		// bench model mirrors the reset state
		ring_head  = '0;
		bar_tally  = '0;
		win_len    = WIN_RESET;
		err_count  = 0;
		burst_left = 0;
		hold_req   = 1'b0;
		walk_base  = 32'h0040_0000;
		flat_left  = 0;
		last_hi    = '0; last_lo = '0; last_cl = '0;
		for (k = 0; k < MAX_WINDOW; k++)
			tp3_ring[k] = '0;

		arst_n                = 1'b0;
		bar_if.valid         <= 1'b0;
		bar_if.high_price    <= '0;
		bar_if.low_price     <= '0;
		bar_if.close_price   <= '0;
		cfg_if.valid         <= 1'b0;
		cfg_if.window_length <= WIN_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (row_i = 0; row_i < DIR_ROWS; row_i++) begin
			row = DIRECTED[row_i];
			case (row.kind)
				ROW_CFG:     write_window(row.wl);
				ROW_BAR:     send_bar(row.hi, row.lo, row.cl, 1'b0, BEAT_NONE);
				ROW_BAR_CHK: send_bar(row.hi, row.lo, row.cl, 1'b1, row.want);
				default:     ;
			endcase
		end

		// random phases, each with its own window length
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			write_window(phase < 8 ? WIN_PLAN[phase] : NW'($urandom_range(0, 31)));
			for (k = 0; k < BARS_PER_PHASE; k++) begin
				// mid-phase, ask the receiver to back right off
				if (phase == 2 && k == 40)
					hold_req = 1'b1;
				next_bar(hi, lo, cl);
				send_bar(hi, lo, cl, 1'b0, BEAT_NONE);
			end
		end

		// drain
		bar_if.valid <= 1'b0;
		while (pending_index.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// ---- result receiver -----------------------------------------------------
	// Stretches of free flow and stretches gated by a rotating bit pattern,
	// plus one long hold-off on request so the unit fills and stalls its input.
	initial begin
		int          stretch;
		int          bit_i;
		logic [15:0] pat;
		bit          free_run;

		res_if.ready <= 1'b0;
		bit_i = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stretch  = $urandom_range(20, 200);
			pat      = 16'($urandom) | 16'h0001;
			free_run = ($urandom_range(0, 2) == 0);
			repeat (stretch) begin
				res_if.ready <= free_run ? 1'b1 : pat[bit_i[3:0]];
				bit_i++;
				@(posedge clk);
			end
		end
	end

	// ---- result scoreboard ---------------------------------------------------
	initial begin
		index_beat_t want;

		beats_taken = 0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
				if (pending_index.size() == 0) begin
					if (err_count < MAX_REPORTS)
						$display("beat %0d: result with nothing pending (cci %0d rdy %b zd %b)",
							beats_taken, res_if.cci_value, res_if.window_ready,
							res_if.zero_deviation);
					err_count++;
				end else begin
					want = pending_index.pop_front();
					if (res_if.cci_value !== want.cci_value ||
						res_if.window_ready !== want.window_ready ||
						res_if.zero_deviation !== want.zero_deviation) begin
						if (err_count < MAX_REPORTS)
							$display("beat %0d: cci exp %0d got %0d, rdy exp %b got %b, zd exp %b got %b",
								beats_taken, want.cci_value, res_if.cci_value,
								want.window_ready, res_if.window_ready,
								want.zero_deviation, res_if.zero_deviation);
						err_count++;
					end
				end
				beats_taken++;
			end
		end
	end

	// ---- watchdog ------------------------------------------------------------
	// Any beat on any channel resets the count.
	initial begin
		int quiet;

		quiet = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((bar_if.valid === 1'b1 && bar_if.ready === 1'b1) ||
				(res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
				(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
